// ===== src/fmms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmms_pkg
// Shared types and constants for the flight mission mode sequencer.
// ----------------------------------------------------------------------------
package fmms_pkg;

  // Tick counter width; elapsed time wraps at this width
  localparam int TICK_WIDTH = 32;
  localparam int WAIT_WIDTH = 32;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TAKEOFF_WAIT = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SEARCH_WAIT  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MISSING_WAIT = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LANDING_WAIT = 2'd3;

  // Configuration reset values
  localparam logic [WAIT_WIDTH-1:0] TAKEOFF_WAIT_RST = 32'd3000;
  localparam logic [WAIT_WIDTH-1:0] SEARCH_WAIT_RST  = 32'd10000;
  localparam logic [WAIT_WIDTH-1:0] MISSING_WAIT_RST = 32'd5000;
  localparam logic [WAIT_WIDTH-1:0] LANDING_WAIT_RST = 32'd5000;

  // Command codes (meaning depends on mode)
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_TAKEOFF = 2'd1;
  localparam logic [1:0] CMD_DISCONN = 2'd2;
  localparam logic [1:0] CMD_SEARCH  = 2'd1;
  localparam logic [1:0] CMD_LAND    = 2'd2;

  // Tracker status codes
  localparam logic [1:0] TRK_NONE     = 2'd0;
  localparam logic [1:0] TRK_FOUND    = 2'd1;
  localparam logic [1:0] TRK_MISSED   = 2'd2;
  localparam logic [1:0] TRK_CAPTURED = 2'd3;

  // Tracker direction codes
  localparam logic [1:0] DIR_HOLD    = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_LEFT    = 2'd2;
  localparam logic [1:0] DIR_RIGHT   = 2'd3;

  // Drive levels, percent
  localparam logic signed [7:0] DRIVE_POS  = 8'sd100;
  localparam logic signed [7:0] DRIVE_NEG  = -8'sd100;
  localparam logic signed [7:0] DRIVE_ZERO = 8'sd0;

  typedef enum logic [3:0] {
    MODE_START    = 4'd0,
    MODE_READY    = 4'd1,
    MODE_TAKEOFF  = 4'd2,
    MODE_HOVER    = 4'd3,
    MODE_SEARCH   = 4'd4,
    MODE_TRACK    = 4'd5,
    MODE_MISSING  = 4'd6,
    MODE_LANDING  = 4'd7,
    MODE_FINISHED = 4'd8
  } mode_t;

  typedef struct packed {
    logic [WAIT_WIDTH-1:0] takeoff_wait;
    logic [WAIT_WIDTH-1:0] search_wait;
    logic [WAIT_WIDTH-1:0] missing_wait;
    logic [WAIT_WIDTH-1:0] landing_wait;
  } cfg_t;

  typedef struct packed {
    logic                  param_valid;
    logic                  connected;
    logic [1:0]            command;
    logic                  target_found;
    logic [1:0]            track_status;
    logic [1:0]            track_direction;
    logic [TICK_WIDTH-1:0] now_tick;
    logic [TICK_WIDTH-1:0] mode_start_tick;
  } step_t;

  typedef struct packed {
    logic              move_flag;
    logic signed [7:0] pitch_cmd;
    logic signed [7:0] yaw_cmd;
    logic signed [7:0] climb_cmd;
  } drive_t;

  typedef struct packed {
    mode_t  mode;
    drive_t drive;
    logic   takeoff_pulse;
    logic   land_pulse;
  } result_t;

  localparam drive_t DRIVE_IDLE = '{move_flag: 1'b0, pitch_cmd: DRIVE_ZERO,
                                    yaw_cmd: DRIVE_ZERO, climb_cmd: DRIVE_ZERO};

endpackage : fmms_pkg
`default_nettype wire

// ===== src/fmms_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmms_if
// Valid/ready channels for sequencer steps and sequencer results.
// ----------------------------------------------------------------------------
interface fmms_step_if;
  import fmms_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  param_valid;
  logic                  connected;
  logic [1:0]            command;
  logic                  target_found;
  logic [1:0]            track_status;
  logic [1:0]            track_direction;
  logic [TICK_WIDTH-1:0] now_tick;
  logic [TICK_WIDTH-1:0] mode_start_tick;

  modport source (
    output valid, param_valid, connected, command, target_found,
           track_status, track_direction, now_tick, mode_start_tick,
    input  ready
  );

  modport sink (
    input  valid, param_valid, connected, command, target_found,
           track_status, track_direction, now_tick, mode_start_tick,
    output ready
  );
endinterface : fmms_step_if

interface fmms_result_if;
  logic              valid;
  logic              ready;
  logic [3:0]        mode;
  logic              move_flag;
  logic signed [7:0] pitch_cmd;
  logic signed [7:0] yaw_cmd;
  logic signed [7:0] climb_cmd;
  logic              takeoff_pulse;
  logic              land_pulse;

  modport source (
    output valid, mode, move_flag, pitch_cmd, yaw_cmd, climb_cmd,
           takeoff_pulse, land_pulse,
    input  ready
  );

  modport sink (
    input  valid, mode, move_flag, pitch_cmd, yaw_cmd, climb_cmd,
           takeoff_pulse, land_pulse,
    output ready
  );
endinterface : fmms_result_if
`default_nettype wire

// ===== src/fmms_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmms_cfg
// Wait-time configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module fmms_cfg
  import fmms_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output cfg_t                            cfg
);

  // Register file with reset defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.takeoff_wait <= TAKEOFF_WAIT_RST;
      cfg.search_wait  <= SEARCH_WAIT_RST;
      cfg.missing_wait <= MISSING_WAIT_RST;
      cfg.landing_wait <= LANDING_WAIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAKEOFF_WAIT: cfg.takeoff_wait <= cfg_data[WAIT_WIDTH-1:0];
        CFG_SEARCH_WAIT:  cfg.search_wait  <= cfg_data[WAIT_WIDTH-1:0];
        CFG_MISSING_WAIT: cfg.missing_wait <= cfg_data[WAIT_WIDTH-1:0];
        CFG_LANDING_WAIT: cfg.landing_wait <= cfg_data[WAIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule : fmms_cfg
`default_nettype wire

// ===== src/fmms_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmms_core
// Mode register, drive latches and the per-step update logic.
// ----------------------------------------------------------------------------
module fmms_core
  import fmms_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  go,      // registered step is consumed this cycle
  input  step_t      step,
  input  cfg_t       cfg,
  output result_t    result   // combinational outcome of this step
);

  mode_t                 mode;
  mode_t                 mode_next;
  drive_t                drive;
  drive_t                drive_next;
  logic                  takeoff_pulse;
  logic                  land_pulse;
  logic [TICK_WIDTH-1:0] elapsed;
  logic [WAIT_WIDTH-1:0] wait_sel;
  logic                  timed_out;

  // Elapsed time, wrapping; compare against the wait of the current mode
  assign elapsed = step.now_tick - step.mode_start_tick;

  always_comb begin
    case (mode)
      MODE_TAKEOFF: wait_sel = cfg.takeoff_wait;
      MODE_SEARCH:  wait_sel = cfg.search_wait;
      MODE_MISSING: wait_sel = cfg.missing_wait;
      MODE_LANDING: wait_sel = cfg.landing_wait;
      default:      wait_sel = cfg.landing_wait;
    endcase
  end

  assign timed_out = ({{(64-TICK_WIDTH){1'b0}}, elapsed} >=
                      {{(64-WAIT_WIDTH){1'b0}}, wait_sel});

  // Next mode
  always_comb begin
    mode_next = mode;
    if (step.param_valid) begin
      case (mode)
        MODE_START:
          if (step.connected) mode_next = MODE_READY;
        MODE_READY:
          if (step.command == CMD_TAKEOFF) mode_next = MODE_TAKEOFF;
          else if (step.command == CMD_DISCONN) mode_next = MODE_FINISHED;
        MODE_TAKEOFF:
          if (timed_out) mode_next = MODE_HOVER;
        MODE_HOVER:
          if (step.command == CMD_SEARCH) mode_next = MODE_SEARCH;
          else if (step.command == CMD_LAND) mode_next = MODE_LANDING;
        MODE_SEARCH:
          if (step.target_found) mode_next = MODE_TRACK;
          else if (timed_out) mode_next = MODE_HOVER;
        MODE_TRACK:
          if (step.track_status == TRK_MISSED) mode_next = MODE_MISSING;
          else if (step.track_status == TRK_CAPTURED) mode_next = MODE_SEARCH;
        MODE_MISSING:
          if (step.target_found) mode_next = MODE_TRACK;
          else if (timed_out) mode_next = MODE_SEARCH;
        MODE_LANDING:
          if (timed_out) mode_next = MODE_READY;
        default: ;
      endcase
    end
  end

  // Drive latches and request pulses
  always_comb begin
    drive_next    = drive;
    takeoff_pulse = 1'b0;
    land_pulse    = 1'b0;
    if (step.param_valid) begin
      case (mode)
        MODE_READY:
          takeoff_pulse = (step.command == CMD_TAKEOFF);
        MODE_TAKEOFF:
          if (timed_out) drive_next = DRIVE_IDLE;
          else drive_next.climb_cmd = DRIVE_POS;
        MODE_HOVER:
          if (step.command == CMD_NONE) drive_next = DRIVE_IDLE;
          else if (step.command == CMD_LAND) land_pulse = 1'b1;
        MODE_SEARCH:
          if (step.target_found) drive_next = DRIVE_IDLE;
          else if (!timed_out) drive_next.yaw_cmd = DRIVE_POS;
        MODE_TRACK:
          if (step.track_status == TRK_FOUND) begin
            case (step.track_direction)
              DIR_HOLD:    drive_next = DRIVE_IDLE;
              DIR_FORWARD: begin
                drive_next.move_flag = 1'b1;
                drive_next.pitch_cmd = DRIVE_POS;
              end
              DIR_LEFT:    drive_next.yaw_cmd = DRIVE_NEG;
              DIR_RIGHT:   drive_next.yaw_cmd = DRIVE_POS;
              default:     drive_next = drive;
            endcase
          end else begin
            drive_next = DRIVE_IDLE;
          end
        MODE_MISSING:
          drive_next = DRIVE_IDLE;
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_START;
      drive <= DRIVE_IDLE;
    end else if (go) begin
      mode  <= mode_next;
      drive <= drive_next;
    end
  end

  assign result.mode          = mode_next;
  assign result.drive         = drive_next;
  assign result.takeoff_pulse = takeoff_pulse;
  assign result.land_pulse    = land_pulse;

  // A pulse only comes with the transition it requests
  a_takeoff_from_ready: assert property (@(posedge clk) disable iff (rst)
    result.takeoff_pulse |-> (mode == MODE_READY && mode_next == MODE_TAKEOFF))
    else $error("takeoff pulse without ready to takeoff transition");

  a_land_from_hover: assert property (@(posedge clk) disable iff (rst)
    result.land_pulse |-> (mode == MODE_HOVER && mode_next == MODE_LANDING))
    else $error("land pulse without hover to landing transition");

  // State only moves when a step is consumed
  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !go |=> ($stable(mode) && $stable(drive)))
    else $error("state changed without a step");

endmodule : fmms_core
`default_nettype wire

// ===== src/flight_mission_mode_sequencer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flight_mission_mode_sequencer_unit
// Drone mission mode sequencer: one step in, one mode/drive result out.
// ----------------------------------------------------------------------------
// Usage:
//   step   - valid/ready channel carrying one sequencer step per transaction.
//   result - valid/ready channel returning exactly one result per step: the
//            mode after the step, the latched drive values and the take-off
//            and land request pulses.
//   cfg_*  - write port for the four wait registers (index 0..3); write only
//            while no step is in flight.
// Path: an accepted step is held in the input register, then passes the update
// logic into the result register, where its result transaction is offered.
// Throughput: one step per cycle while the result sink holds ready high; the
// only loop is the update of the mode register and drive latches.
// Reset: the mode returns to start, drive latches clear, waits take their
// defaults and both stages empty.
// Stall: when the result sink holds ready low, the result register and the
// input register each keep one step; step.ready falls once both are full.
// ----------------------------------------------------------------------------
module flight_mission_mode_sequencer_unit
  import fmms_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  fmms_step_if.sink                       step,
  fmms_result_if.source                   result,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  cfg_t    cfg;
  step_t   in_item;
  logic    in_vld;
  result_t core_result;
  result_t out_item;
  logic    out_vld;
  logic    advance;

  fmms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline control
  assign advance    = in_vld && (!out_vld || result.ready);
  assign step.ready = !in_vld || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (step.ready) begin
      in_vld <= step.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid && step.ready) begin
      in_item.param_valid     <= step.param_valid;
      in_item.connected       <= step.connected;
      in_item.command         <= step.command;
      in_item.target_found    <= step.target_found;
      in_item.track_status    <= step.track_status;
      in_item.track_direction <= step.track_direction;
      in_item.now_tick        <= step.now_tick;
      in_item.mode_start_tick <= step.mode_start_tick;
    end
  end

  fmms_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (advance),
    .step   (in_item),
    .cfg    (cfg),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
    end
  end

  assign result.valid         = out_vld;
  assign result.mode          = out_item.mode;
  assign result.move_flag     = out_item.drive.move_flag;
  assign result.pitch_cmd     = out_item.drive.pitch_cmd;
  assign result.yaw_cmd       = out_item.drive.yaw_cmd;
  assign result.climb_cmd     = out_item.drive.climb_cmd;
  assign result.takeoff_pulse = out_item.takeoff_pulse;
  assign result.land_pulse    = out_item.land_pulse;

  // Both stages are empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!in_vld && !out_vld))
    else $error("pipeline not empty after reset");

  // A consumed step always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_vld)
    else $error("result lost after advance");

  // Never both request pulses in one result
  a_pulse_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(out_item.takeoff_pulse && out_item.land_pulse))
    else $error("takeoff and land pulses together");

endmodule : flight_mission_mode_sequencer_unit
`default_nettype wire
